// ===== hw/rtl/ihb_pkg.sv =====
package ihb_pkg;

  localparam int SampleWidth  = 16;
  localparam int TapCount     = 62;
  localparam int NumPairs     = 15;
  localparam int NumProducts  = NumPairs + 1;
  localparam int NumGroups    = 4;
  localparam int GroupSize    = NumProducts / NumGroups;
  localparam int CenterAge    = 32;
  localparam int AccWidth     = 32;
  localparam int OutShift     = 15;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [SampleWidth:0]   pair_t;
  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic signed [15:0]            coef_t;

  localparam coef_t CenterWeight = 16'sd16384;

  localparam coef_t PairCoef [NumPairs] = '{
    16'sd10387, -16'sd3347, 16'sd1876, -16'sd1209, 16'sd818,
    -16'sd561,  16'sd381,   -16'sd254, 16'sd164,   -16'sd102,
    16'sd60,    -16'sd32,   16'sd16,   -16'sd6,    16'sd1
  };

  typedef struct packed {
    logic shift;
    logic ld_prod;
    logic ld_group;
    logic ld_out;
  } ctrl_t;

endpackage

// ===== hw/rtl/ihb_tap_line.sv =====
module ihb_tap_line (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  ihb_pkg::sample_t sample_i,
  output ihb_pkg::sample_t taps_o [ihb_pkg::TapCount]
);

  ihb_pkg::sample_t taps_q [ihb_pkg::TapCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ihb_pkg::TapCount; k++) begin
        taps_q[k] <= '0;
      end
    end else if (shift_i) begin
      taps_q[0] <= sample_i;
      for (int k = 1; k < ihb_pkg::TapCount; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end
  end

  assign taps_o = taps_q;

endmodule

// ===== hw/rtl/ihb_filter.sv =====
module ihb_filter (
  input  logic             clk_i,
  input  ihb_pkg::ctrl_t   ctrl_i,
  input  ihb_pkg::sample_t taps_i [ihb_pkg::TapCount],
  output ihb_pkg::sample_t out_o,
  output logic             wrapped_o
);

  ihb_pkg::pair_t              pair_sum [ihb_pkg::NumPairs];
  logic signed [ihb_pkg::AccWidth:0] prod_full [ihb_pkg::NumProducts];
  ihb_pkg::acc_t               prod_d   [ihb_pkg::NumProducts];
  ihb_pkg::acc_t               prod_q   [ihb_pkg::NumProducts];
  ihb_pkg::acc_t               group_d  [ihb_pkg::NumGroups];
  ihb_pkg::acc_t               group_q  [ihb_pkg::NumGroups];
  ihb_pkg::acc_t               total;
  ihb_pkg::sample_t            out_d, out_q;
  logic                        wrapped_d, wrapped_q;

  // symmetric pairs: ages 31-2k and 33+2k
  always_comb begin
    for (int k = 0; k < ihb_pkg::NumPairs; k++) begin
      pair_sum[k]  = 17'(taps_i[ihb_pkg::CenterAge - 1 - 2*k])
                   + 17'(taps_i[ihb_pkg::CenterAge + 1 + 2*k]);
      prod_full[k] = pair_sum[k] * ihb_pkg::PairCoef[k];
    end
    prod_full[ihb_pkg::NumPairs] = taps_i[ihb_pkg::CenterAge] * ihb_pkg::CenterWeight;
    for (int k = 0; k < ihb_pkg::NumProducts; k++) begin
      prod_d[k] = prod_full[k][ihb_pkg::AccWidth-1:0];
    end
  end

  always_comb begin
    for (int g = 0; g < ihb_pkg::NumGroups; g++) begin
      group_d[g] = '0;
      for (int j = 0; j < ihb_pkg::GroupSize; j++) begin
        group_d[g] = group_d[g] + prod_q[g*ihb_pkg::GroupSize + j];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < ihb_pkg::NumGroups; g++) begin
      total = total + group_q[g];
    end
    out_d     = total[ihb_pkg::OutShift + ihb_pkg::SampleWidth - 1:ihb_pkg::OutShift];
    wrapped_d = total[ihb_pkg::AccWidth-1] ^ total[ihb_pkg::AccWidth-2];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.ld_group) begin
      group_q <= group_d;
    end
    if (ctrl_i.ld_out) begin
      out_q     <= out_d;
      wrapped_q <= wrapped_d;
    end
  end

  assign out_o     = out_q;
  assign wrapped_o = wrapped_q;

endmodule

// ===== hw/rtl/ihb_ctrl.sv =====
module ihb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ihb_pkg::ctrl_t ctrl_o
);

  logic tap_vld_q, prod_vld_q, group_vld_q, out_vld_q;
  logic tap_rdy, prod_rdy, group_rdy, out_rdy;

  // each stage moves when its successor is empty or moving
  assign out_rdy   = !out_vld_q   || out_ready_i;
  assign group_rdy = !group_vld_q || out_rdy;
  assign prod_rdy  = !prod_vld_q  || group_rdy;
  assign tap_rdy   = !tap_vld_q   || prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      group_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (tap_rdy)   tap_vld_q   <= in_valid_i;
      if (prod_rdy)  prod_vld_q  <= tap_vld_q;
      if (group_rdy) group_vld_q <= prod_vld_q;
      if (out_rdy)   out_vld_q   <= group_vld_q;
    end
  end

  assign ctrl_o.shift    = in_valid_i  && tap_rdy;
  assign ctrl_o.ld_prod  = tap_vld_q   && prod_rdy;
  assign ctrl_o.ld_group = prod_vld_q  && group_rdy;
  assign ctrl_o.ld_out   = group_vld_q && out_rdy;

  assign in_ready_o  = tap_rdy;
  assign out_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/iq_half_band_fir.sv =====
// 59-tap symmetric half-band FIR on a complex (I/Q) sample stream.
// Input channel: in_valid_i/in_ready_o with one signed 16-bit I/Q pair per word.
// Output channel: out_valid_o/out_ready_i with the filtered pair and one wrap
// flag per rail, set when the shifted sum left the 16-bit signed range (the
// sample then carries its low 16 bits).
// Pipeline: an accepted word passes the tap line, product register, group-sum
// register and output register to output valid, 4 pipeline stages in all.
// Throughput: one word per cycle while the output is taken.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse; a stalled receiver backs the pipe up and in_ready_o drops only
// once all four stages hold words.
// Reset (rst_ni low, asynchronous) clears both tap lines to zero and empties
// the pipeline; the first outputs see zeros at unfilled ages.
module iq_half_band_fir (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ihb_pkg::sample_t in_i_i,
  input  ihb_pkg::sample_t in_q_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ihb_pkg::sample_t out_i_o,
  output ihb_pkg::sample_t out_q_o,
  output logic             i_wrapped_o,
  output logic             q_wrapped_o
);

  ihb_pkg::ctrl_t   ctrl;
  ihb_pkg::sample_t taps_i [ihb_pkg::TapCount];
  ihb_pkg::sample_t taps_q [ihb_pkg::TapCount];

  ihb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  ihb_tap_line u_taps_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (ctrl.shift),
    .sample_i (in_i_i),
    .taps_o   (taps_i)
  );

  ihb_tap_line u_taps_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (ctrl.shift),
    .sample_i (in_q_i),
    .taps_o   (taps_q)
  );

  ihb_filter u_fir_i (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .taps_i    (taps_i),
    .out_o     (out_i_o),
    .wrapped_o (i_wrapped_o)
  );

  ihb_filter u_fir_q (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .taps_i    (taps_q),
    .out_o     (out_q_o),
    .wrapped_o (q_wrapped_o)
  );

endmodule

// ===== hw/rtl/ihb_checker.sv =====
module ihb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ihb_pkg::sample_t out_i_o,
  input ihb_pkg::sample_t out_q_o,
  input logic             i_wrapped_o,
  input logic             q_wrapped_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_i_o)
      && $stable(out_q_o) && $stable(i_wrapped_o) && $stable(q_wrapped_o))
    else $error("output word changed under stall");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i) |=> out_valid_o)
    else $error("accepted word not delivered after three cycles");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");

endmodule

bind iq_half_band_fir ihb_checker u_ihb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_i_o     (out_i_o),
  .out_q_o     (out_q_o),
  .i_wrapped_o (i_wrapped_o),
  .q_wrapped_o (q_wrapped_o)
);
